@@ rtl/cms_pkg.sv @@
`default_nettype none
package cms_pkg;

    localparam int COEF_W    = 24;
    localparam int KEY_W     = 31;
    localparam int CNT_W     = 32;
    localparam int VAL_W     = 56;
    localparam int DIG_W     = 4;
    localparam int MOD_STEPS = VAL_W / DIG_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);
    localparam int COL_DIG_W = 8;
    localparam int COL_REM_W = 16;
    localparam int COL_T_W   = COL_REM_W + COL_DIG_W;
    localparam int COL_MAG_W = COL_T_W + 1;
    localparam int COL_PRD_W = COL_T_W + COL_MAG_W;
    localparam int COL_STEPS = VAL_W / COL_DIG_W;
    localparam int COL_CNT_W = $clog2(COL_STEPS);
    localparam logic signed [CNT_W-1:0] EST_CAP = 32'sd1073741824;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_e;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_PSTART,
        ST_PRUN,
        ST_WSTART,
        ST_WRUN,
        ST_READ,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [1:0]              row;
        logic [KEY_W-1:0]        key;
        logic signed [CNT_W-1:0] amount;
        logic [COEF_W-1:0]       hash_mult;
        logic [COEF_W-1:0]       hash_add;
        logic [COEF_W-1:0]       hash_prime;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]        query_key;
        logic signed [CNT_W-1:0] estimate;
    } rsp_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic mul;
        logic mod_start;
        logic mod_src_rem;
        logic mem_rd;
        logic acc;
        logic row_next;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic prime_zero;
        logic mod_busy;
        logic last_row;
        logic is_query;
        logic out_blocked;
    } stat_t;

endpackage
`default_nettype wire

@@ rtl/cms_mod.sv @@
`default_nettype none
module cms_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [cms_pkg::VAL_W-1:0]  value,
    input  wire logic [cms_pkg::COEF_W-1:0] divisor,
    output logic                            busy,
    output logic [cms_pkg::COEF_W-1:0]      rem
);
    import cms_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [COEF_W-1:0]   div_reg, div_next;
    logic [COEF_W-1:0]   rem_reg, rem_next;

    // Restoring remainder, DIG_W bits per cycle from the top of the value.
    always_comb
    begin
        logic [COEF_W:0]   t;
        logic [COEF_W-1:0] r;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        r         = rem_reg;
        t         = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(MOD_STEPS - 1);
            val_next  = value;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < DIG_W; i++)
            begin
                t = {r, val_reg[VAL_W-1-i]};
                if (t >= {1'b0, div_reg})
                    t = t - {1'b0, div_reg};
                r = t[COEF_W-1:0];
            end
            rem_next = r;
            val_next = val_reg << DIG_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ rtl/cms_dp.sv @@
`default_nettype none
module cms_dp #(
    parameter int NUM_ROWS = 4,
    parameter int WIDTH    = 16384
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cms_pkg::ctrl_t ctl,
    output cms_pkg::stat_t      st,
    input  wire cms_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output cms_pkg::rsp_t       rsp
);
    import cms_pkg::*;

    localparam int DEPTH  = NUM_ROWS * WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int COL_W  = $clog2(WIDTH);
    localparam int RW     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COL_SH = COL_T_W + COL_W;
    localparam longint unsigned COL_RECIP =
        ((64'd1 << COL_SH) + 64'(WIDTH) - 64'd1) / 64'(WIDTH);
    localparam logic [COL_MAG_W-1:0] COL_MAGIC = COL_MAG_W'(COL_RECIP);

    logic [COEF_W-1:0] mult_mem  [NUM_ROWS];
    logic [COEF_W-1:0] add_mem   [NUM_ROWS];
    logic [COEF_W-1:0] prime_mem [NUM_ROWS];
    logic [CNT_W-1:0]  cnt_mem   [DEPTH];

    logic [AW-1:0]           clr_addr_reg;
    logic [RW-1:0]           row_idx_reg;
    logic [AW-1:0]           row_base_reg;
    logic [1:0]              cmd_reg;
    logic [KEY_W-1:0]        key_reg;
    logic signed [CNT_W-1:0] amount_reg;
    logic [VAL_W-1:0]        v_reg;
    logic [AW-1:0]           addr_reg;
    logic signed [CNT_W-1:0] rd_reg;
    logic signed [CNT_W-1:0] best_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg;

    logic                    col_busy_reg, col_busy_next;
    logic                    col_ph_reg, col_ph_next;
    logic [COL_CNT_W-1:0]    col_cnt_reg, col_cnt_next;
    logic [VAL_W-1:0]        col_val_reg, col_val_next;
    logic [COL_REM_W-1:0]    col_rem_reg, col_rem_next;
    logic [COL_T_W-1:0]      col_t_reg, col_t_next;
    logic [COL_T_W-1:0]      col_q_reg, col_q_next;

    logic                    mod_busy;
    logic [COEF_W-1:0]       mod_rem;
    logic [VAL_W-1:0]        mod_value;
    logic [COEF_W-1:0]       mod_div;
    logic                    col_sel;
    logic                    prime_start;
    logic                    col_start;
    logic [COL_T_W-1:0]      col_t;
    logic [COL_PRD_W-1:0]    col_prod;
    logic [COL_PRD_W-1:0]    col_qw;
    logic [AW-1:0]           addr;
    logic signed [CNT_W:0]   sum;
    logic signed [CNT_W-1:0] sat;
    logic                    coef_wr;

    assign coef_wr = ctl.capture && (req.command == CMD_LOAD) &&
                     ({3'b000, req.row} < 5'(NUM_ROWS));

    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            mult_mem[RW'(req.row)]  <= req.hash_mult;
            add_mem[RW'(req.row)]   <= req.hash_add;
            prime_mem[RW'(req.row)] <= req.hash_prime;
        end
    end

    // A zero prime skips straight to the column reduction of the raw value.
    assign col_sel     = ctl.mod_src_rem || st.prime_zero;
    assign prime_start = ctl.mod_start && !col_sel;
    assign col_start   = ctl.mod_start && col_sel;
    assign mod_value   = ctl.mod_src_rem ? VAL_W'(mod_rem) : v_reg;
    assign mod_div     = prime_mem[row_idx_reg];

    cms_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (prime_start),
        .value   (v_reg),
        .divisor (mod_div),
        .busy    (mod_busy),
        .rem     (mod_rem)
    );

    // Column remainder, one byte per step: first the quotient of each partial
    // value by reciprocal multiplication, then subtract the quotient times WIDTH.
    assign col_t    = {col_rem_reg, col_val_reg[VAL_W-1 -: COL_DIG_W]};
    assign col_prod = COL_PRD_W'(col_t) * COL_PRD_W'(COL_MAGIC);
    assign col_qw   = COL_PRD_W'(col_q_reg) * COL_PRD_W'(WIDTH);

    always_comb
    begin
        col_busy_next = col_busy_reg;
        col_ph_next   = col_ph_reg;
        col_cnt_next  = col_cnt_reg;
        col_val_next  = col_val_reg;
        col_rem_next  = col_rem_reg;
        col_t_next    = col_t_reg;
        col_q_next    = col_q_reg;
        if (col_start)
        begin
            col_busy_next = 1'b1;
            col_ph_next   = 1'b0;
            col_cnt_next  = COL_CNT_W'(COL_STEPS - 1);
            col_val_next  = mod_value;
            col_rem_next  = '0;
        end
        else if (col_busy_reg)
        begin
            if (!col_ph_reg)
            begin
                col_t_next   = col_t;
                col_q_next   = COL_T_W'(col_prod >> COL_SH);
                col_val_next = col_val_reg << COL_DIG_W;
                col_ph_next  = 1'b1;
            end
            else
            begin
                col_rem_next = COL_REM_W'(COL_PRD_W'(col_t_reg) - col_qw);
                col_ph_next  = 1'b0;
                col_cnt_next = col_cnt_reg - 1'b1;
                if (col_cnt_reg == '0)
                    col_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_busy_reg <= 1'b0;
            col_ph_reg   <= 1'b0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            col_busy_reg <= col_busy_next;
            col_ph_reg   <= col_ph_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_val_reg <= col_val_next;
        col_rem_reg <= col_rem_next;
        col_t_reg   <= col_t_next;
        col_q_reg   <= col_q_next;
    end

    assign addr = row_base_reg + AW'(col_rem_reg[COL_W-1:0]);

    always_comb
    begin
        sum = {amount_reg[CNT_W-1], amount_reg} + {rd_reg[CNT_W-1], rd_reg};
        if (sum[CNT_W] != sum[CNT_W-1])
            sat = sum[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        else
            sat = sum[CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr_step)
            cnt_mem[clr_addr_reg] <= '0;
        else if (ctl.acc && !st.is_query)
            cnt_mem[addr_reg] <= sat;
        if (ctl.mem_rd)
            rd_reg <= cnt_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            row_idx_reg   <= '0;
            row_base_reg  <= '0;
            cmd_reg       <= CMD_LOAD;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.clr_step)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (ctl.capture)
            begin
                cmd_reg      <= req.command;
                row_idx_reg  <= '0;
                row_base_reg <= '0;
            end
            else if (ctl.row_next)
            begin
                row_idx_reg  <= row_idx_reg + 1'b1;
                row_base_reg <= row_base_reg + AW'(WIDTH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            key_reg    <= req.key;
            amount_reg <= req.amount;
            best_reg   <= EST_CAP;
        end
        else if (ctl.acc && st.is_query && (rd_reg < best_reg))
            best_reg <= rd_reg;
        if (ctl.mul)
            v_reg <= VAL_W'(mult_mem[row_idx_reg]) * VAL_W'(key_reg)
                   + VAL_W'(add_mem[row_idx_reg]);
        if (ctl.mem_rd)
            addr_reg <= addr;
        if (ctl.out_load)
        begin
            rsp_reg.query_key <= key_reg;
            rsp_reg.estimate  <= best_reg;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (ctl.out_load)
            rsp_valid_next = 1'b1;
    end

    assign st.clr_last    = (clr_addr_reg == AW'(DEPTH - 1));
    assign st.prime_zero  = (prime_mem[row_idx_reg] == '0);
    assign st.mod_busy    = mod_busy || col_busy_reg;
    assign st.last_row    = (row_idx_reg == RW'(NUM_ROWS - 1));
    assign st.is_query    = (cmd_reg == CMD_QUERY);
    assign st.out_blocked = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

@@ rtl/cms_ctrl.sv @@
`default_nettype none
module cms_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic [1:0]     req_cmd,
    output logic                req_stall,
    input  wire cms_pkg::stat_t st,
    output cms_pkg::ctrl_t      ctl
);
    import cms_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (st.clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (req_valid && (req_cmd == CMD_UPDATE || req_cmd == CMD_QUERY))
                    state_next = ST_MUL;
            end
            ST_MUL:    state_next = ST_PSTART;
            ST_PSTART: state_next = st.prime_zero ? ST_WSTART : ST_PRUN;
            ST_PRUN:   if (!st.mod_busy) state_next = ST_WSTART;
            ST_WSTART: state_next = ST_WRUN;
            ST_WRUN:   if (!st.mod_busy) state_next = ST_READ;
            ST_READ:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (!st.last_row)
                    state_next = ST_MUL;
                else
                    state_next = st.is_query ? ST_OUT : ST_IDLE;
            end
            ST_OUT:    if (!st.out_blocked) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:  ctl.clr_step = 1'b1;
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                ctl.capture = req_valid;
            end
            ST_MUL:    ctl.mul = 1'b1;
            ST_PSTART: ctl.mod_start = !st.prime_zero;
            ST_WSTART:
            begin
                // Reduce the raw value when the prime pass was skipped.
                ctl.mod_start   = 1'b1;
                ctl.mod_src_rem = !st.prime_zero;
            end
            ST_READ:   ctl.mem_rd = 1'b1;
            ST_ACC:
            begin
                ctl.acc      = 1'b1;
                ctl.row_next = !st.last_row;
            end
            ST_OUT:    ctl.out_load = !st.out_blocked;
            default:   ctl = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/count_min_sketch_table.sv @@
`default_nettype none
// Load and unused commands are taken in the idle state; update and query capture the
// request, then run each row in turn (a row with a zero prime skips the prime remainder):
// multiply, prime remainder at 4 bits per cycle, column remainder one byte per step,
// counter read, then write-back (update) or minimum (query). One item at a time.
// A query adds an output step (held while the previous result is stalled); its result
// holds until taken. After reset the counter memory is cleared with req_stall high.
module count_min_sketch_table #(
    parameter int NUM_ROWS = 4,
    parameter int WIDTH    = 16384
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire cms_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output cms_pkg::rsp_t      rsp
);
    import cms_pkg::*;

    ctrl_t ctl;
    stat_t st;

    cms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.command),
        .req_stall (req_stall),
        .st        (st),
        .ctl       (ctl)
    );

    cms_dp #(
        .NUM_ROWS (NUM_ROWS),
        .WIDTH    (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .st        (st),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

@@ verif/count_min_sketch_table_tb.sv @@
`default_nettype none
module count_min_sketch_table_tb;
    import cms_pkg::*;

    localparam int ROWS         = 4;
    localparam int COLS         = 16384;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 600;
    localparam int REQ_W        = $bits(req_t);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [COEF_W-1:0] COEF_MAX = 24'hFFFFFF;
    localparam logic [KEY_W-1:0]  KEY_MAX  = 31'h7FFFFFFF;

    class sketch_tracker;
        int signed          counts[ROWS*COLS];
        logic [COEF_W-1:0]  mult[ROWS];
        logic [COEF_W-1:0]  add[ROWS];
        logic [COEF_W-1:0]  prime[ROWS];
        rsp_t               estimates_q[$];
        int                 errors;

        function int unsigned column(int r, logic [KEY_W-1:0] key);
            longint unsigned v;
            v = longint'({40'd0, mult[r]}) * longint'({33'd0, key}) + longint'({40'd0, add[r]});
            if (prime[r] != 0)
                v = v % longint'({40'd0, prime[r]});
            return int'(v % COLS);
        endfunction

        function void note_request(req_t q);
            longint s;
            int     idx;
            int signed best;
            rsp_t   e;
            case (q.command)
                CMD_LOAD:
                    if (q.row < ROWS)
                    begin
                        mult[q.row]  = q.hash_mult;
                        add[q.row]   = q.hash_add;
                        prime[q.row] = q.hash_prime;
                    end
                CMD_UPDATE:
                    for (int r = 0; r < ROWS; r++)
                    begin
                        idx = r*COLS + column(r, q.key);
                        s = longint'(counts[idx]) + longint'(q.amount);
                        if (s > 64'sd2147483647)
                            s = 64'sd2147483647;
                        if (s < -64'sd2147483648)
                            s = -64'sd2147483648;
                        counts[idx] = int'(s);
                    end
                CMD_QUERY:
                begin
                    best = EST_CAP;
                    for (int r = 0; r < ROWS; r++)
                    begin
                        idx = r*COLS + column(r, q.key);
                        if (counts[idx] < best)
                            best = counts[idx];
                    end
                    e.query_key = q.key;
                    e.estimate  = best;
                    estimates_q = {estimates_q, e};
                end
                default: ;
            endcase
        endfunction

        function void check_estimate(rsp_t got);
            rsp_t e;
            if (estimates_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result key=%0d est=%0d", got.query_key, got.estimate);
                return;
            end
            e = estimates_q.pop_front();
            if (got.query_key !== e.query_key || got.estimate !== e.estimate)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected key=%0d est=%0d, got key=%0d est=%0d",
                             e.query_key, e.estimate, got.query_key, got.estimate);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    sketch_tracker     sketch;
    int                send_idle_pct;
    int                stall_pct;
    int                cycles;
    logic [KEY_W-1:0]  hot_keys[24];

    count_min_sketch_table #(.NUM_ROWS(ROWS), .WIDTH(COLS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side: random stall, check each transfer
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                sketch.check_estimate(rsp);
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sketch.note_request(item);
    endtask

    function automatic req_t coef_load(logic [1:0] row, logic [COEF_W-1:0] m,
                                       logic [COEF_W-1:0] a, logic [COEF_W-1:0] p);
        req_t q;
        q = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        q.command    = CMD_LOAD;
        q.row        = row;
        q.hash_mult  = m;
        q.hash_add   = a;
        q.hash_prime = p;
        return q;
    endfunction

    function automatic req_t keyed(logic [1:0] cmd, logic [KEY_W-1:0] key, int signed amt);
        req_t q;
        q = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        q.command = cmd;
        q.key     = key;
        q.amount  = amt;
        return q;
    endfunction

    function automatic req_t random_request();
        req_t q;
        int   pick;
        q = req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        if ($urandom_range(99) < 80)
            q.key = hot_keys[$urandom_range(23)];
        if ($urandom_range(99) < 75)
            q.amount = $signed($urandom_range(2000)) - 1000;
        q.hash_mult  = COEF_W'($urandom_range(COEF_MAX, 2));
        q.hash_add   = COEF_W'($urandom_range(COEF_MAX, 2));
        q.hash_prime = COEF_W'(($urandom_range(3) == 0) ? $urandom_range(40, 2)
                                                        : $urandom_range(COEF_MAX, 2));
        if (pick < 4)
            q.command = CMD_LOAD;
        else if (pick < 50)
            q.command = CMD_UPDATE;
        else if (pick < 97)
            q.command = CMD_QUERY;
        else
            q.command = CMD_UNUSED;
        return q;
    endfunction

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sketch.estimates_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sketch = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hot_keys[0] = '0;
        hot_keys[1] = KEY_MAX;
        for (int i = 2; i < 24; i++)
            hot_keys[i] = KEY_W'($urandom_range(i < 12 ? 64 : 32'h7FFFFFFF, 0));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every row before any lookup
        send_item(coef_load(2'd0, COEF_MAX, COEF_MAX, COEF_MAX));
        send_item(coef_load(2'd1, 24'd2, 24'd2, 24'd2));
        send_item(coef_load(2'd2, COEF_W'($urandom_range(COEF_MAX, 2)),
                            COEF_W'($urandom_range(COEF_MAX, 2)), 24'd13));
        send_item(coef_load(2'd3, 24'd3, 24'd5, 24'd16777213));
        send_item(keyed(CMD_QUERY, '0, 0));
        send_item(keyed(CMD_UPDATE, '0, 32'sh7FFFFFFF));
        send_item(keyed(CMD_UPDATE, '0, 100));
        send_item(keyed(CMD_QUERY, '0, 0));
        send_item(keyed(CMD_UPDATE, KEY_MAX, 32'sh80000000));
        send_item(keyed(CMD_UPDATE, KEY_MAX, -1));
        send_item(keyed(CMD_QUERY, KEY_MAX, 0));
        send_item(keyed(CMD_UNUSED, 31'd5, 77));
        send_item(keyed(CMD_UPDATE, 31'd5, 1000));
        send_item(keyed(CMD_UPDATE, 31'd5, -1500));
        send_item(keyed(CMD_QUERY, 31'd5, 0));
        send_item(keyed(CMD_UPDATE, 31'd6, 32'sh40000001));
        send_item(keyed(CMD_QUERY, 31'd6, 0));
        send_item(keyed(CMD_QUERY, 31'h2AAAAAAA, 0));
        // hold the sender until every estimate is back
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 46 : (phase == 3) ? 31 : 0;
            stall_pct     = (phase == 2) ? 46 : (phase == 3) ? 31 : 0;
            for (int i = 0; i < RANDOM_ITEMS/4; i++)
                send_item(random_request());
        end
        send_idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sketch.errors == 0 && sketch.estimates_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
